// File: sv/rdcw_pkg.sv
// rdcw_pkg: widths, depths and types shared by the range distinct count window
// block and its port checker. No dependencies.
package rdcw_pkg;

   localparam int ElemAw    = 10;               // element index width
   localparam int ValAw     = 10;               // element value width
   localparam int ElemDepth = 1 << ElemAw;
   localparam int ValRange  = 1 << ValAw;
   localparam int CountW    = $clog2(ElemDepth + 1);
   localparam int TagW      = 16;

   typedef logic [ElemAw-1:0] elem_addr_type;
   typedef logic [ValAw-1:0]  value_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [TagW-1:0]   tag_type;

endpackage

// File: sv/range_distinct_count_window.sv
// range_distinct_count_window: distinct values over a sliding index window.
// Depends on rdcw_pkg (widths, types). Element and count stores are internal.
//
// Usage and timing. After reset the block sweeps the per-value count store to
// zero, one entry per cycle, and holds busy high while it sweeps; nothing is
// taken during that sweep. An item transfers at a rising edge with start high
// and busy low. A load whose position lies outside the current window is
// written in the transfer cycle itself and the block stays ready. A load
// inside the window counts the new value in and the old value out, which
// keeps busy high until both counts are written. A query with range_start >
// range_end is answered in the next cycle with bad_range set and a zero count;
// the window does not move. A valid query walks the window ends one index per
// step; each step is a decision, an element read, a count read and a count
// write on the shared increment/decrement unit, and the answer appears on the
// rsp_ ports the cycle busy falls. The first valid query after reset has no
// window to start from and counts its whole range in. Every answer is shown
// for exactly one cycle under rsp_strobe; there is no way to stall it, so
// capture it when the strobe is high. Reading an index that was never loaded
// gives an unspecified count.
module range_distinct_count_window (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic [rdcw_pkg::ElemAw-1:0] req_position,
   input  logic [rdcw_pkg::ValAw-1:0]  req_element_value,
   input  logic [rdcw_pkg::ElemAw-1:0] req_range_start,
   input  logic [rdcw_pkg::ElemAw-1:0] req_range_end,
   input  logic [rdcw_pkg::TagW-1:0]   req_query_tag,
   output logic                      rsp_strobe,
   output logic [rdcw_pkg::TagW-1:0]   rsp_answer_tag,
   output logic [rdcw_pkg::CountW-1:0] rsp_distinct_count,
   output logic                      rsp_bad_range
);

   // sequencer states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StClear  = 3'd1;
   localparam logic [2:0] StPlan   = 3'd2;
   localparam logic [2:0] StElemRd = 3'd3;
   localparam logic [2:0] StCntRd  = 3'd4;
   localparam logic [2:0] StCntWr  = 3'd5;

   // what the current count update belongs to
   localparam logic [1:0] JobQuery   = 2'd0;
   localparam logic [1:0] JobLoadIn  = 2'd1;
   localparam logic [1:0] JobLoadOut = 2'd2;

   localparam logic OpLoad  = 1'b0;

   localparam logic DirOut = 1'b0;
   localparam logic DirIn  = 1'b1;

   // storage
   rdcw_pkg::value_type elem_mem [rdcw_pkg::ElemDepth];
   rdcw_pkg::count_type cnt_mem  [rdcw_pkg::ValRange];

   logic [2:0]              state_ff, state_in;
   logic [1:0]              job_ff, job_in;
   logic                    dir_ff, dir_in;
   logic                    src_elem_ff, src_elem_in;
   rdcw_pkg::elem_addr_type step_pos_ff, step_pos_in;
   rdcw_pkg::elem_addr_type win_low_ff, win_low_in;
   rdcw_pkg::elem_addr_type win_high_ff, win_high_in;
   logic                    win_empty_ff, win_empty_in;
   rdcw_pkg::count_type     total_ff, total_in;
   rdcw_pkg::value_type     clr_idx_ff, clr_idx_in;
   rdcw_pkg::elem_addr_type ld_pos_ff, ld_pos_in;
   rdcw_pkg::value_type     ld_val_ff, ld_val_in;
   rdcw_pkg::elem_addr_type q_start_ff, q_start_in;
   rdcw_pkg::elem_addr_type q_end_ff, q_end_in;
   rdcw_pkg::tag_type       q_tag_ff, q_tag_in;
   rdcw_pkg::value_type     elem_q_ff;
   rdcw_pkg::count_type     cnt_q_ff;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rdcw_pkg::tag_type       rsp_tag_ff, rsp_tag_in;
   rdcw_pkg::count_type     rsp_count_ff, rsp_count_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic                    accept;
   logic                    ld_in_window;
   rdcw_pkg::value_type     cnt_addr;
   rdcw_pkg::count_type     cnt_new;
   logic                    cnt_change;
   logic                    elem_we;
   rdcw_pkg::elem_addr_type elem_wa;
   rdcw_pkg::value_type     elem_wd;
   logic                    cnt_we;
   rdcw_pkg::value_type     cnt_wa;
   rdcw_pkg::count_type     cnt_wd;

   assign busy   = (state_ff != StIdle);
   assign accept = start && !busy;

   assign ld_in_window = !win_empty_ff && (req_position >= win_low_ff)
                         && (req_position <= win_high_ff);

   // count address: the element just read, or the value being loaded
   assign cnt_addr = src_elem_ff ? elem_q_ff : ld_val_ff;

   // shared increment/decrement unit; a count already at zero never drops
   assign cnt_new    = cnt_q_ff + ((dir_ff == DirIn) ? rdcw_pkg::CountW'(1) : '1);
   assign cnt_change = (dir_ff == DirIn) || (cnt_q_ff != '0);

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      dir_in        = dir_ff;
      src_elem_in   = src_elem_ff;
      step_pos_in   = step_pos_ff;
      win_low_in    = win_low_ff;
      win_high_in   = win_high_ff;
      win_empty_in  = win_empty_ff;
      total_in      = total_ff;
      clr_idx_in    = clr_idx_ff;
      ld_pos_in     = ld_pos_ff;
      ld_val_in     = ld_val_ff;
      q_start_in    = q_start_ff;
      q_end_in      = q_end_ff;
      q_tag_in      = q_tag_ff;
      rsp_strobe_in = 1'b0;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_bad_in    = rsp_bad_ff;

      case (state_ff)
         StClear: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (accept) begin
               ld_pos_in  = req_position;
               ld_val_in  = req_element_value;
               q_start_in = req_range_start;
               q_end_in   = req_range_end;
               q_tag_in   = req_query_tag;
               if (req_op == OpLoad) begin
                  // out-of-window loads are written right away
                  if (ld_in_window) begin
                     job_in      = JobLoadIn;
                     dir_in      = DirIn;
                     src_elem_in = 1'b0;
                     step_pos_in = req_position;
                     state_in    = StElemRd;
                  end
               end else if (req_range_start > req_range_end) begin
                  rsp_strobe_in = 1'b1;
                  rsp_tag_in    = req_query_tag;
                  rsp_count_in  = '0;
                  rsp_bad_in    = 1'b1;
               end else begin
                  job_in   = JobQuery;
                  state_in = StPlan;
               end
            end
         end
         StPlan: begin
            // grow low, grow high, shrink low, shrink high, then answer
            src_elem_in = 1'b1;
            state_in    = StElemRd;
            if (win_empty_ff) begin
               dir_in       = DirIn;
               step_pos_in  = q_start_ff;
               win_low_in   = q_start_ff;
               win_high_in  = q_start_ff;
               win_empty_in = 1'b0;
            end else if (win_low_ff > q_start_ff) begin
               dir_in      = DirIn;
               step_pos_in = win_low_ff - 1'b1;
               win_low_in  = win_low_ff - 1'b1;
            end else if (win_high_ff < q_end_ff) begin
               dir_in      = DirIn;
               step_pos_in = win_high_ff + 1'b1;
               win_high_in = win_high_ff + 1'b1;
            end else if (win_low_ff < q_start_ff) begin
               dir_in      = DirOut;
               step_pos_in = win_low_ff;
               win_low_in  = win_low_ff + 1'b1;
            end else if (win_high_ff > q_end_ff) begin
               dir_in      = DirOut;
               step_pos_in = win_high_ff;
               win_high_in = win_high_ff - 1'b1;
            end else begin
               state_in      = StIdle;
               rsp_strobe_in = 1'b1;
               rsp_tag_in    = q_tag_ff;
               rsp_count_in  = total_ff;
               rsp_bad_in    = 1'b0;
            end
         end
         StElemRd: begin
            state_in = StCntRd;
         end
         StCntRd: begin
            state_in = StCntWr;
         end
         StCntWr: begin
            if (dir_ff == DirIn) begin
               if (cnt_q_ff == '0) begin
                  total_in = total_ff + 1'b1;
               end
            end else if (cnt_q_ff == rdcw_pkg::CountW'(1)) begin
               total_in = total_ff - 1'b1;
            end
            case (job_ff)
               JobLoadIn: begin
                  // new value counted in; now count the old one out
                  job_in      = JobLoadOut;
                  dir_in      = DirOut;
                  src_elem_in = 1'b1;
                  state_in    = StCntRd;
               end
               JobLoadOut: begin
                  state_in = StIdle;
               end
               default: begin
                  state_in = StPlan;
               end
            endcase
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // element store port: one write, one registered read
   always_comb begin
      if (state_ff == StIdle) begin
         elem_we = accept && (req_op == OpLoad) && !ld_in_window;
         elem_wa = req_position;
         elem_wd = req_element_value;
      end else begin
         elem_we = (state_ff == StCntWr) && (job_ff == JobLoadIn);
         elem_wa = ld_pos_ff;
         elem_wd = ld_val_ff;
      end
   end

   // count store port: clearing sweep or step write-back
   always_comb begin
      if (state_ff == StClear) begin
         cnt_we = 1'b1;
         cnt_wa = clr_idx_ff;
         cnt_wd = '0;
      end else begin
         cnt_we = (state_ff == StCntWr) && cnt_change;
         cnt_wa = cnt_addr;
         cnt_wd = cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wa] <= elem_wd;
      end
      if (state_ff == StElemRd) begin
         elem_q_ff <= elem_mem[step_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (state_ff == StCntRd) begin
         cnt_q_ff <= cnt_mem[cnt_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StClear;
         clr_idx_ff    <= '0;
         win_low_ff    <= '0;
         win_high_ff   <= '0;
         win_empty_ff  <= 1'b1;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         job_ff        <= JobQuery;
         dir_ff        <= DirIn;
         src_elem_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         win_low_ff    <= win_low_in;
         win_high_ff   <= win_high_in;
         win_empty_ff  <= win_empty_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
         job_ff        <= job_in;
         dir_ff        <= dir_in;
         src_elem_ff   <= src_elem_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      step_pos_ff  <= step_pos_in;
      ld_pos_ff    <= ld_pos_in;
      ld_val_ff    <= ld_val_in;
      q_start_ff   <= q_start_in;
      q_end_ff     <= q_end_in;
      q_tag_ff     <= q_tag_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_answer_tag     = rsp_tag_ff;
   assign rsp_distinct_count = rsp_count_ff;
   assign rsp_bad_range      = rsp_bad_ff;

endmodule

// File: sv/rdcw_checker.sv
// rdcw_checker: port-level assertions for range_distinct_count_window,
// attached by bind. Depends on rdcw_pkg for port widths.
module rdcw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_op,
   input logic [rdcw_pkg::ElemAw-1:0] req_range_start,
   input logic [rdcw_pkg::ElemAw-1:0] req_range_end,
   input logic [rdcw_pkg::TagW-1:0]   req_query_tag,
   input logic                        rsp_strobe,
   input logic [rdcw_pkg::TagW-1:0]   rsp_answer_tag,
   input logic [rdcw_pkg::CountW-1:0] rsp_distinct_count,
   input logic                        rsp_bad_range
);

   logic take;
   assign take = start && !busy;

   // a rejected range is answered in the next cycle with its own tag
   a_bad_range_answer: assert property (@(posedge clock) disable iff (reset)
      take && req_op && (req_range_start > req_range_end) |=>
         rsp_strobe && rsp_bad_range && (rsp_answer_tag == $past(req_query_tag)))
      else $error("rejected range not answered next cycle");

   // a rejected range reports zero distinct values
   a_bad_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bad_range |-> (rsp_distinct_count == '0))
      else $error("bad range with nonzero count");

   // a load never produces an answer
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      take && !req_op |=> !rsp_strobe)
      else $error("answer after a load transfer");

   // a valid query occupies the block until it is answered
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      take && req_op && (req_range_start <= req_range_end) |=> busy && !rsp_strobe)
      else $error("valid query did not hold busy");

   // the count never exceeds the number of elements
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_distinct_count <= rdcw_pkg::CountW'(rdcw_pkg::ElemDepth)))
      else $error("distinct count out of range");

endmodule

bind range_distinct_count_window rdcw_checker u_rdcw_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_op             (req_op),
   .req_range_start    (req_range_start),
   .req_range_end      (req_range_end),
   .req_query_tag      (req_query_tag),
   .rsp_strobe         (rsp_strobe),
   .rsp_answer_tag     (rsp_answer_tag),
   .rsp_distinct_count (rsp_distinct_count),
   .rsp_bad_range      (rsp_bad_range)
);

// File: sim/testbench.sv
// Self-checking testbench for range_distinct_count_window: loads and range queries
// driven through the start/busy command port, answers checked against a scoreboard.
// Depends on rdcw_pkg and range_distinct_count_window.
`timescale 1ns / 1ps

typedef enum logic {
   OP_LOAD  = 1'b0,
   OP_QUERY = 1'b1
} req_kind_type;

typedef struct {
   rdcw_pkg::tag_type   tag;
   rdcw_pkg::count_type cnt;
   logic                bad;
} answer_rec_type;

// Scoreboard: mirrors the element array, the per-value occurrence counts and the
// window, and queues one expected answer per accepted query.
class distinct_window_board;
   bit [rdcw_pkg::ValAw-1:0] elem_mem [rdcw_pkg::ElemDepth];
   int unsigned              occ [rdcw_pkg::ValRange];
   int                       win_lo;
   int                       win_hi;
   bit                       win_none;
   int unsigned              distinct;
   answer_rec_type           pending [$];
   int                       errors;

   function new();
      win_none = 1'b1;
   endfunction

   task report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
   endtask

   function void tally_in(rdcw_pkg::value_type v);
      occ[v]++;
      if (occ[v] == 1) distinct++;
   endfunction

   function void tally_out(rdcw_pkg::value_type v);
      if (occ[v] == 0) return;
      occ[v]--;
      if (occ[v] == 0) distinct--;
   endfunction

   function void note_item(req_kind_type op, rdcw_pkg::elem_addr_type pos,
                           rdcw_pkg::value_type val, rdcw_pkg::elem_addr_type rs,
                           rdcw_pkg::elem_addr_type re, rdcw_pkg::tag_type tag);
      answer_rec_type ans;
      int             s;
      int             e;
      int             i;
      int             lo;
      int             hi;
      s = rs;
      e = re;
      if (op == OP_LOAD) begin
         // swap the counted value only when the position is inside the window
         if (!win_none && pos >= win_lo && pos <= win_hi) begin
            tally_in(val);
            tally_out(elem_mem[pos]);
         end
         elem_mem[pos] = val;
         return;
      end
      ans.tag = tag;
      if (s > e) begin
         ans.cnt = '0;
         ans.bad = 1'b1;
         pending.push_back(ans);
         return;
      end
      if (win_none) begin
         for (i = s; i <= e; i++) tally_in(elem_mem[i]);
         win_none = 1'b0;
      end else begin
         // widen first, then narrow, so no count drops below zero
         for (i = win_lo; i > s; i--) tally_in(elem_mem[i-1]);
         for (i = win_hi + 1; i <= e; i++) tally_in(elem_mem[i]);
         lo = (s < win_lo) ? s : win_lo;
         hi = (e > win_hi) ? e : win_hi;
         for (i = lo; i < s; i++) tally_out(elem_mem[i]);
         for (i = hi; i > e; i--) tally_out(elem_mem[i]);
      end
      win_lo  = s;
      win_hi  = e;
      ans.cnt = rdcw_pkg::count_type'(distinct);
      ans.bad = 1'b0;
      pending.push_back(ans);
   endfunction

   task check_answer(rdcw_pkg::tag_type tag, rdcw_pkg::count_type cnt, logic bad);
      answer_rec_type want;
      if (pending.size() == 0) begin
         report_mismatch($sformatf("answer tag %h with no query outstanding", tag));
         return;
      end
      want = pending.pop_front();
      if (tag !== want.tag)
         report_mismatch($sformatf("tag %h, expected %h", tag, want.tag));
      if (cnt !== want.cnt)
         report_mismatch($sformatf("tag %h: distinct_count %0d, expected %0d",
                                   want.tag, cnt, want.cnt));
      if (bad !== want.bad)
         report_mismatch($sformatf("tag %h: bad_range %b, expected %b",
                                   want.tag, bad, want.bad));
   endtask
endclass

module testbench;

   localparam int RandItems  = 1450;
   localparam int QuietTail  = 150;     // last items run back to back
   localparam int DrainLimit = 20000;   // the longest query walk fits well inside this limit
   localparam int SettleWait = 16;      // covers the busy time of an in-window load

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_op;
   rdcw_pkg::elem_addr_type req_position;
   rdcw_pkg::value_type     req_element_value;
   rdcw_pkg::elem_addr_type req_range_start;
   rdcw_pkg::elem_addr_type req_range_end;
   rdcw_pkg::tag_type       req_query_tag;
   logic                    rsp_strobe;
   rdcw_pkg::tag_type       rsp_answer_tag;
   rdcw_pkg::count_type     rsp_distinct_count;
   logic                    rsp_bad_range;

   distinct_window_board board;

   // positions loaded so far; valid queries stay below fill_top, where all are written
   bit written [rdcw_pkg::ElemDepth];
   int fill_top;

   range_distinct_count_window uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_position       (req_position),
      .req_element_value  (req_element_value),
      .req_range_start    (req_range_start),
      .req_range_end      (req_range_end),
      .req_query_tag      (req_query_tag),
      .rsp_strobe         (rsp_strobe),
      .rsp_answer_tag     (rsp_answer_tag),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_bad_range      (rsp_bad_range)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Capture each answer at the edge that ends its strobe cycle; the block
   // cannot be held off, so every strobe is one transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            board.check_answer(rsp_answer_tag, rsp_distinct_count, rsp_bad_range);
         else if (rsp_strobe !== 1'b0)
            board.report_mismatch("rsp_strobe unknown");
      end
   end

   // Present one item and hold it until the transfer edge (start high, busy low).
   // Return at that edge with start still high.
   task automatic send_item(input req_kind_type op, input rdcw_pkg::elem_addr_type pos,
                            input rdcw_pkg::value_type val,
                            input rdcw_pkg::elem_addr_type rs,
                            input rdcw_pkg::elem_addr_type re,
                            input rdcw_pkg::tag_type tag);
      req_op            <= op;
      req_position      <= pos;
      req_element_value <= val;
      req_range_start   <= rs;
      req_range_end     <= re;
      req_query_tag     <= tag;
      start             <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_item(op, pos, val, rs, re, tag);
   endtask

   // Drop start for a burst of idle cycles.
   task automatic pause_input(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Load with random junk on the query fields, then advance the written frontier.
   task automatic do_load(input rdcw_pkg::elem_addr_type pos,
                          input rdcw_pkg::value_type val);
      send_item(OP_LOAD, pos, val, rdcw_pkg::elem_addr_type'($urandom),
                rdcw_pkg::elem_addr_type'($urandom), rdcw_pkg::tag_type'($urandom));
      written[pos] = 1'b1;
      while (fill_top < rdcw_pkg::ElemDepth && written[fill_top]) fill_top++;
   endtask

   // Query with random junk on the load fields.
   task automatic do_query(input rdcw_pkg::elem_addr_type rs,
                           input rdcw_pkg::elem_addr_type re,
                           input rdcw_pkg::tag_type tag);
      send_item(OP_QUERY, rdcw_pkg::elem_addr_type'($urandom),
                rdcw_pkg::value_type'($urandom), rs, re, tag);
   endtask

   initial begin
      int             n;
      int             pick;
      int             room;
      int             lo;
      int             hi;
      int             swap;
      int             guard;
      bit             calm;
      answer_rec_type left;

      board             = new();
      fill_top          = 0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_op            <= OP_LOAD;
      req_position      <= '0;
      req_element_value <= '0;
      req_range_start   <= '0;
      req_range_end     <= '0;
      req_query_tag     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: seed a few elements, reject a range before any window
      // exists, open the window, grow and shrink it, and swap elements inside it.
      do_load(0, 10'h000);
      do_load(1, 10'h3FF);
      do_load(2, 10'h2AA);
      do_load(3, 10'h155);
      do_load(4, 10'h000);
      do_query(10'h3FF, 10'h000, 16'hFFFF);   // start after end, no window yet
      do_query(1, 3, 16'h0000);               // first valid query counts whole range
      do_query(0, 4, 16'h5555);               // grow both ends
      do_query(2, 2, 16'hAAAA);               // shrink both ends
      do_load(2, 10'h3FF);                    // inside window, value changes
      do_load(10'h3FF, 10'h3FF);              // top position, outside window
      do_load(10'h200, 10'h155);
      do_query(2, 2, 16'h0001);               // no move at all
      do_query(0, 4, 16'h0002);
      do_load(4, 10'h001);                    // inside window, fresh value
      do_load(3, 10'h155);                    // inside window, same value
      do_query(3, 4, 16'h0003);
      do_query(4, 3, 16'h0004);               // start one past end
      do_query(10'h3FF, 10'h3FE, 16'h0005);
      do_query(0, 0, 16'h0006);
      do_query(0, 4, 16'h0007);

      // Random part: mostly extend the written region, with queries that move
      // the window by small steps, a few jumps, bad ranges and in-window loads.
      calm = 1'b0;
      for (n = 0; n < RandItems; n++) begin
         if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         if (!calm && n < RandItems - QuietTail && $urandom_range(0, 99) < 30)
            pause_input($urandom_range(1, 7));
         room = fill_top - 1;
         if (fill_top < rdcw_pkg::ElemDepth && $urandom_range(0, 99) < 85) begin
            do_load(rdcw_pkg::elem_addr_type'(fill_top), rdcw_pkg::value_type'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               if (pick < 10)
                  do_load(rdcw_pkg::elem_addr_type'($urandom_range(board.win_lo,
                                                                   board.win_hi)),
                          rdcw_pkg::value_type'($urandom));
               else
                  do_load(rdcw_pkg::elem_addr_type'($urandom),
                          rdcw_pkg::value_type'($urandom));
            end else if (pick < 27) begin
               lo = $urandom_range(1, rdcw_pkg::ElemDepth - 1);
               hi = $urandom_range(0, lo - 1);
               do_query(rdcw_pkg::elem_addr_type'(lo), rdcw_pkg::elem_addr_type'(hi),
                        rdcw_pkg::tag_type'($urandom));
            end else begin
               if (pick < 85) begin
                  // step each end by up to 16 positions
                  lo = board.win_lo + int'($urandom_range(0, 32)) - 16;
                  hi = board.win_hi + int'($urandom_range(0, 32)) - 16;
                  if (lo < 0) lo = 0;
                  if (hi < 0) hi = 0;
                  if (lo > room) lo = room;
                  if (hi > room) hi = room;
               end else if (pick < 96) begin
                  // jump to a short range anywhere in the written region
                  lo = $urandom_range(0, room);
                  hi = lo + int'($urandom_range(0, 63));
                  if (hi > room) hi = room;
               end else begin
                  lo = $urandom_range(0, room);
                  hi = $urandom_range(0, room);
               end
               if (lo > hi) begin
                  swap = lo;
                  lo   = hi;
                  hi   = swap;
               end
               do_query(rdcw_pkg::elem_addr_type'(lo), rdcw_pkg::elem_addr_type'(hi),
                        rdcw_pkg::tag_type'($urandom));
            end
         end
      end
      start <= 1'b0;

      // Drain outstanding answers, then let a trailing in-window load settle.
      guard = 0;
      while (board.pending.size() != 0 && guard < DrainLimit) begin
         @(posedge clock);
         guard++;
      end
      repeat (SettleWait) @(posedge clock);
      while (board.pending.size() != 0) begin
         left = board.pending.pop_front();
         board.report_mismatch($sformatf("no answer for tag %h", left.tag));
      end

      if (board.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #40_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
